/* hdl/cab_pkg.sv */
// Package for the clipped alpha blit core: item types, register codes and the blend function.
// Used by the interfaces and by every module of the core; depends on nothing else.
`timescale 1ns / 1ps

package cab_pkg;

    localparam int MAX_DIM = 4096;
    localparam int CNT_W   = $clog2(MAX_DIM);
    localparam int CFG_W   = 13;
    localparam int POS_W   = CFG_W + 1;
    localparam int IDX_W   = 24;
    localparam int PROD_W  = 2 * CFG_W;

    typedef enum logic [2:0] {
        REG_SCREEN_WIDTH  = 3'd0,
        REG_SCREEN_HEIGHT = 3'd1,
        REG_SRC_WIDTH     = 3'd2,
        REG_SRC_HEIGHT    = 3'd3,
        REG_POS_X         = 3'd4,
        REG_POS_Y         = 3'd5
    } cab_reg_e;

    typedef logic [2:0]       cab_addr_t;
    typedef logic [CFG_W-1:0] cab_data_t;

    typedef struct packed {
        logic [7:0] tex_c0;
        logic [7:0] tex_c1;
        logic [7:0] tex_c2;
        logic [7:0] tex_alpha;
        logic [7:0] bg_c0;
        logic [7:0] bg_c1;
        logic [7:0] bg_c2;
        logic [7:0] bg_alpha;
    } blit_in_t;

    typedef struct packed {
        logic             write_en;
        logic [IDX_W-1:0] pixel_index;
        logic [7:0]       out_c0;
        logic [7:0]       out_c1;
        logic [7:0]       out_c2;
        logic [7:0]       out_alpha;
        logic             last;
    } blit_out_t;

    typedef struct packed {
        logic [CFG_W-1:0]        screen_width;
        logic [CFG_W-1:0]        screen_height;
        logic [CNT_W:0]          src_w_eff;
        logic [CNT_W:0]          src_h_eff;
        logic signed [CFG_W-1:0] pos_x;
        logic signed [CFG_W-1:0] pos_y;
    } cab_cfg_t;

    typedef struct packed {
        blit_in_t         px;
        logic [CNT_W-1:0] col;
        logic [CNT_W-1:0] row;
        logic             last;
    } cab_stage_t;

    // A source size of zero acts as one and anything above the maximum is clamped.
    function automatic logic [CNT_W:0] eff_dim(input logic [CFG_W-1:0] v);
        logic [CNT_W:0] r;
        if (v == '0) begin
            r = (CNT_W+1)'(1);
        end else if (32'(v) > 32'(MAX_DIM)) begin
            r = (CNT_W+1)'(MAX_DIM);
        end else begin
            r = (CNT_W+1)'(v);
        end
        return r;
    endfunction

    // Returns bg + floor(a * (tex - bg) / 256), kept to eight bits.
    function automatic logic [7:0] blend_ch(input logic [7:0] a, input logic [7:0] tex,
                                            input logic [7:0] bg);
        logic signed [8:0]  diff;
        logic signed [17:0] prod;
        logic [9:0]         q;
        logic [9:0]         sum;
        diff = $signed({1'b0, tex}) - $signed({1'b0, bg});
        prod = $signed({1'b0, a}) * diff;
        q    = prod[17:8];
        sum  = {2'b00, bg} + q;
        return sum[7:0];
    endfunction

endpackage

/* hdl/cab_ifs.sv */
// Handshake interfaces of the clipped alpha blit core: texel input, pixel output, config writes.
// Depends on cab_pkg for the item types.
`timescale 1ns / 1ps

interface cab_in_if import cab_pkg::*; ();
    logic     valid;
    logic     ready;
    blit_in_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface cab_out_if import cab_pkg::*; ();
    logic      valid;
    logic      ready;
    blit_out_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface cab_cfg_if import cab_pkg::*; ();
    logic      valid;
    logic      ready;
    cab_addr_t index;
    cab_data_t data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

/* hdl/cab_cfg_regs.sv */
// Configuration register file of the clipped alpha blit core.
// Depends on cab_pkg and cab_cfg_if.
`timescale 1ns / 1ps

module cab_cfg_regs import cab_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    cab_cfg_if.sink    cfg_wr,
    output cab_cfg_t   cfg
);

    logic [CFG_W-1:0] screen_w_reg;
    logic [CFG_W-1:0] screen_h_reg;
    logic [CFG_W-1:0] src_w_reg;
    logic [CFG_W-1:0] src_h_reg;
    logic [CFG_W-1:0] pos_x_reg;
    logic [CFG_W-1:0] pos_y_reg;

    assign cfg_wr.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            screen_w_reg <= CFG_W'(1024);
            screen_h_reg <= CFG_W'(768);
            src_w_reg    <= CFG_W'(64);
            src_h_reg    <= CFG_W'(64);
            pos_x_reg    <= '0;
            pos_y_reg    <= '0;
        end
        else if (cfg_wr.valid)
        begin
            case (cfg_wr.index)
                REG_SCREEN_WIDTH:  screen_w_reg <= cfg_wr.data;
                REG_SCREEN_HEIGHT: screen_h_reg <= cfg_wr.data;
                REG_SRC_WIDTH:     src_w_reg    <= cfg_wr.data;
                REG_SRC_HEIGHT:    src_h_reg    <= cfg_wr.data;
                REG_POS_X:         pos_x_reg    <= cfg_wr.data;
                REG_POS_Y:         pos_y_reg    <= cfg_wr.data;
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        cfg.screen_width  = screen_w_reg;
        cfg.screen_height = screen_h_reg;
        cfg.src_w_eff     = eff_dim(src_w_reg);
        cfg.src_h_eff     = eff_dim(src_h_reg);
        cfg.pos_x         = $signed(pos_x_reg);
        cfg.pos_y         = $signed(pos_y_reg);
    end

endmodule

/* hdl/cab_src_stage.sv */
// Input stage of the clipped alpha blit core: source column and row counters and input register.
// Depends on cab_pkg and cab_in_if.
`timescale 1ns / 1ps

module cab_src_stage import cab_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    cab_in_if.sink      src,
    input  cab_cfg_t    cfg,
    input  logic        advance,
    output logic        stage_valid,
    output cab_stage_t  stage
);

    logic [CNT_W-1:0] col_reg;
    logic [CNT_W-1:0] col_next;
    logic [CNT_W-1:0] row_reg;
    logic [CNT_W-1:0] row_next;
    logic             valid_reg;
    cab_stage_t       stage_reg;
    logic             accept;
    logic             col_end;
    logic             row_end;

    assign src.ready   = !valid_reg || advance;
    assign accept      = src.valid && src.ready;
    assign stage_valid = valid_reg;
    assign stage       = stage_reg;

    always_comb
    begin
        col_end = ({1'b0, col_reg} + (CNT_W+1)'(1)) >= cfg.src_w_eff;
        row_end = ({1'b0, row_reg} + (CNT_W+1)'(1)) >= cfg.src_h_eff;
        if (col_end)
        begin
            col_next = '0;
            row_next = row_end ? '0 : row_reg + CNT_W'(1);
        end
        else
        begin
            col_next = col_reg + CNT_W'(1);
            row_next = row_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            row_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                col_reg   <= col_next;
                row_reg   <= row_next;
                valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_reg.px   <= src.payload;
            stage_reg.col  <= col_reg;
            stage_reg.row  <= row_reg;
            stage_reg.last <= col_end && row_end;
        end
    end

endmodule

/* hdl/cab_blend_out.sv */
// Clip, index and blend logic of the clipped alpha blit core, followed by the output register.
// Depends on cab_pkg and cab_out_if.
`timescale 1ns / 1ps

module cab_blend_out import cab_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        stage_valid,
    input  cab_stage_t  stage,
    input  cab_cfg_t    cfg,
    output logic        advance,
    cab_out_if.source   dst
);

    logic                    out_valid_reg;
    blit_out_t               out_reg;
    blit_out_t               out_next;
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic                    visible;
    logic [PROD_W-1:0]       row_base;
    logic [IDX_W-1:0]        index;

    assign advance     = !out_valid_reg || dst.ready;
    assign dst.valid   = out_valid_reg;
    assign dst.payload = out_reg;

    always_comb
    begin
        x = $signed({cfg.pos_x[CFG_W-1], cfg.pos_x})
            + $signed({{(POS_W-CNT_W){1'b0}}, stage.col});
        y = $signed({cfg.pos_y[CFG_W-1], cfg.pos_y})
            + $signed({{(POS_W-CNT_W){1'b0}}, stage.row});
        visible = !x[POS_W-1] && !y[POS_W-1]
                  && (x[CFG_W-1:0] < cfg.screen_width)
                  && (y[CFG_W-1:0] < cfg.screen_height);
        row_base = y[CFG_W-1:0] * cfg.screen_width;
        index    = row_base[IDX_W-1:0] + {{(IDX_W-CFG_W){1'b0}}, x[CFG_W-1:0]};

        out_next      = '0;
        out_next.last = stage.last;
        if (visible && (stage.px.tex_alpha != 8'd0))
        begin
            out_next.write_en    = 1'b1;
            out_next.pixel_index = index;
            if (stage.px.tex_alpha == 8'd255)
            begin
                out_next.out_c0    = stage.px.tex_c0;
                out_next.out_c1    = stage.px.tex_c1;
                out_next.out_c2    = stage.px.tex_c2;
                out_next.out_alpha = 8'd255;
            end
            else
            begin
                out_next.out_c0    = blend_ch(stage.px.tex_alpha, stage.px.tex_c0,
                                              stage.px.bg_c0);
                out_next.out_c1    = blend_ch(stage.px.tex_alpha, stage.px.tex_c1,
                                              stage.px.bg_c1);
                out_next.out_c2    = blend_ch(stage.px.tex_alpha, stage.px.tex_c2,
                                              stage.px.bg_c2);
                out_next.out_alpha = stage.px.bg_alpha;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= stage_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && stage_valid)
        begin
            out_reg <= out_next;
        end
    end

endmodule

/* hdl/clipped_alpha_blit_core.sv */
// Clipped alpha blit core: an accepted texel item is held in the input register and then in the
// output register. Throughput is one item per cycle unless dst.ready stalls the output; the input
// and output registers form a two-stage pipeline with the clip, index multiply and blend logic between them.
// Reset clears the column and row counters and the valid flags and loads the register
// defaults (1024 x 768 screen, 64 x 64 source, position zero). Depends on cab_pkg and cab_ifs.
`timescale 1ns / 1ps

module clipped_alpha_blit_core import cab_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    cab_cfg_if.sink    cfg,
    cab_in_if.sink     src,
    cab_out_if.source  dst
);

    cab_cfg_t   cfg_q;
    logic       advance;
    logic       stage_valid;
    cab_stage_t stage;

    cab_cfg_regs u_cfg_regs (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg_wr (cfg),
        .cfg    (cfg_q)
    );

    cab_src_stage u_src_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .src         (src),
        .cfg         (cfg_q),
        .advance     (advance),
        .stage_valid (stage_valid),
        .stage       (stage)
    );

    cab_blend_out u_blend_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .stage_valid (stage_valid),
        .stage       (stage),
        .cfg         (cfg_q),
        .advance     (advance),
        .dst         (dst)
    );

endmodule
